### sv/obm_pkg.sv
// obm_pkg: shared types and constants of the order book matcher
// used by obm_div, obm_ctrl, obm_dpath and order_book_matcher
package obm_pkg;

  localparam int unsigned PriceW   = 24;
  localparam int unsigned QtyW     = 20;
  localparam int unsigned ProdW    = 8;
  localparam int unsigned TraderW  = 8;
  localparam int unsigned OidW     = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned PctW     = 7;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned FeeW     = 40;
  localparam int unsigned TotalW   = 63;
  // qty*price*pct+50 fits in 51 bits
  localparam int unsigned ProdFeeW = 51;
  localparam int unsigned Mul1W    = QtyW + PriceW;
  localparam int unsigned RemW     = 7;
  localparam int unsigned DivCntW  = 6;
  localparam logic [RemW:0] FeeDivisor = 8'd100;
  localparam logic [PctW-1:0] FeePctReset = 7'd1;
  localparam logic [FeeW-1:0] FeeMax = {FeeW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // fee divider: four 16-bit digits, each divided by 100 through a reciprocal
  // multiply that is exact for any 23-bit partial dividend
  localparam int unsigned DivDigW  = 16;
  localparam int unsigned DivRegW  = 64;
  localparam int unsigned DivSteps = 4;
  localparam int unsigned DivVW    = RemW + DivDigW;
  localparam int unsigned RecipW   = 24;
  localparam int unsigned DivMulW  = DivVW + RecipW;
  localparam int unsigned DivShift = 30;
  localparam logic [RecipW-1:0] DivRecip = 24'd10737419;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 176;

  // result status codes
  localparam logic [StatusW-1:0] StStored    = 3'd0;
  localparam logic [StatusW-1:0] StTraded    = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StCancelled = 3'd3;
  localparam logic [StatusW-1:0] StNotFound  = 3'd4;

  localparam logic ActPlace  = 1'b0;
  localparam logic ActCancel = 1'b1;
  localparam logic SideBuy   = 1'b0;

  // one table entry as held in the memory
  typedef struct packed {
    logic [StampW-1:0]  stamp;
    logic [OidW-1:0]    oid;
    logic [TraderW-1:0] trader;
    logic [QtyW-1:0]    qty;
    logic [PriceW-1:0]  price;
    logic [ProdW-1:0]   prod;
    logic               side;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic wr_new;
    logic wr_best;
    logic div_start;
    logic fin;
    logic out_load;
    logic [StatusW-1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_cancel;
    logic scan_done;
    logic found;
    logic slot_found;
    logic trade_ok;
    logic div_done;
  } sts_t;

endpackage

### sv/order_book_matcher.sv
// order_book_matcher: top level, limit order book with one trade per order
// depends on obm_pkg, obm_ctrl, obm_dpath
//
// Each input word is a new limit order or a cancel and gives exactly one
// result word. Every item walks the whole order table through its single
// read port, one entry a cycle. A trade adds the write-back of the resting
// order, two multiplies and the fee divider, which finds one 16-bit
// quotient digit a cycle by reciprocal multiply over four digits. A new
// word is taken while the previous result still waits on the output side.
// Equal prices go to the earliest order; a full table rejects new orders.
module order_book_matcher #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,   // fee_percent
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // side, product, price, quantity, trader, order number, zero fill
  input  logic [79:0]   s_axis_tdata,
  input  logic          s_axis_tuser,  // action
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // trade_quantity, trade_price, trade_fee, resting_trader,
  // resting order number, incoming_filled, resting_filled, fee_total, zero fill
  output logic [175:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser   // status
);

  obm_pkg::cmd_t cmd;
  obm_pkg::sts_t sts;

  obm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  obm_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

### sv/obm_div.sv
// obm_div: fee divider by a fixed 100, one 16-bit quotient digit per cycle
// depends on obm_pkg
module obm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [obm_pkg::ProdFeeW-1:0]    dividend_i,
  output logic                            done_o,
  output logic [obm_pkg::ProdFeeW-1:0]    quot_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [obm_pkg::DivCntW-1:0]     cnt_q;
  logic [obm_pkg::RemW-1:0]        rem_q;
  logic [obm_pkg::DivRegW-1:0]     quot_q;
  logic [obm_pkg::DivVW-1:0]       part;
  logic [obm_pkg::DivMulW-1:0]     part_mul;
  logic [obm_pkg::DivDigW-1:0]     qdig;
  logic [obm_pkg::DivVW-1:0]       qdig_x100;

  // partial dividend: remainder so far and the next digit from the top
  assign part = {rem_q, quot_q[obm_pkg::DivRegW-1 -: obm_pkg::DivDigW]};

  // quotient digit by reciprocal multiply, then the new remainder
  assign part_mul  = obm_pkg::DivMulW'(part) * obm_pkg::DivMulW'(obm_pkg::DivRecip);
  assign qdig      = part_mul[obm_pkg::DivShift +: obm_pkg::DivDigW];
  assign qdig_x100 = obm_pkg::DivVW'(qdig) * obm_pkg::DivVW'(obm_pkg::FeeDivisor);

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= obm_pkg::DivCntW'(obm_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == obm_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= obm_pkg::DivRegW'(dividend_i);
    end else if (busy_q) begin
      rem_q  <= obm_pkg::RemW'(part - qdig_x100);
      quot_q <= {quot_q[obm_pkg::DivRegW-obm_pkg::DivDigW-1:0], qdig};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q[obm_pkg::ProdFeeW-1:0];

endmodule

### sv/obm_ctrl.sv
// obm_ctrl: sequencing state machine of the order book matcher
// depends on obm_pkg
module obm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  obm_pkg::sts_t   sts_i,
  output obm_pkg::cmd_t   cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_WNEW  = 8'b0000_0100,
    S_WBEST = 8'b0000_1000,
    S_DGO   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [obm_pkg::StatusW-1:0] status_q, status_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.is_cancel) begin
            status_d = sts_i.found ? obm_pkg::StCancelled : obm_pkg::StNotFound;
            state_d  = S_RES;
          end else if (!sts_i.slot_found) begin
            status_d = obm_pkg::StFull;
            state_d  = S_RES;
          end else begin
            state_d = S_WNEW;
          end
        end
      end
      S_WNEW: begin
        cmd_o.wr_new = 1'b1;
        if (sts_i.trade_ok) begin
          state_d = S_WBEST;
        end else begin
          status_d = obm_pkg::StStored;
          state_d  = S_RES;
        end
      end
      S_WBEST: begin
        cmd_o.wr_best = 1'b1;
        state_d = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        status_d = obm_pkg::StTraded;
        state_d  = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= obm_pkg::StStored;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/obm_dpath.sv
// obm_dpath: order table memory, scan, trade arithmetic and result register
// depends on obm_pkg and obm_div
module obm_dpath #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  obm_pkg::cmd_t                    cmd_i,
  output obm_pkg::sts_t                    sts_o,
  input  logic                             cfg_we_i,
  input  logic [obm_pkg::PctW-1:0]         cfg_wdata_i,
  input  logic                             in_action_i,
  input  logic [obm_pkg::InDataW-1:0]      in_data_i,
  output logic [obm_pkg::StatusW-1:0]      out_status_o,
  output logic [obm_pkg::OutDataW-1:0]     out_data_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // table storage
  obm_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] open_q;

  // captured input
  logic                          act_q;
  obm_pkg::entry_t               in_q;
  logic [obm_pkg::PctW-1:0]      pct_q;
  logic [obm_pkg::StampW-1:0]    ctr_q;
  logic [obm_pkg::TotalW-1:0]    acc_q;

  // scan pipeline
  logic [CW-1:0]   cnt_q;
  logic            issue;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  obm_pkg::entry_t rd_q;
  logic            rd_open_q;
  logic            found_q;
  logic            slot_found_q;
  logic [IW-1:0]   slot_q;
  logic            best_found_q;
  logic [IW-1:0]   best_idx_q;
  obm_pkg::entry_t best_q;

  // trade arithmetic
  logic [obm_pkg::QtyW-1:0]      tq;
  logic [obm_pkg::QtyW-1:0]      tq_q;
  logic [obm_pkg::QtyW-1:0]      new_rem;
  logic [obm_pkg::QtyW-1:0]      best_rem;
  logic                          trade_ok;
  logic [obm_pkg::Mul1W-1:0]     prod1_q;
  logic [obm_pkg::ProdFeeW-1:0]  prod2_q;
  logic                          in_fill_q;
  logic                          rest_fill_q;
  logic [obm_pkg::ProdFeeW-1:0]  quot;
  logic                          div_done;
  logic [obm_pkg::FeeW-1:0]      fee_q;
  logic [obm_pkg::TotalW:0]      acc_sum;

  // memory write port
  logic            we;
  logic [IW-1:0]   waddr;
  obm_pkg::entry_t wdata;

  // candidate checks
  logic cand_ok;
  logic cand_beats;
  logic [obm_pkg::StampW-1:0] age_cand;
  logic [obm_pkg::StampW-1:0] age_best;

  assign issue = cmd_i.scan && (cnt_q != CW'(ENTRIES));

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q      <= mem[cnt_q[IW-1:0]];
    rd_open_q <= open_q[cnt_q[IW-1:0]];
    rd_idx_q  <= cnt_q[IW-1:0];
  end

  // candidate filter and ranking, ages taken against the counter after this order
  assign age_cand = ctr_q + obm_pkg::StampW'(1) - rd_q.stamp;
  assign age_best = ctr_q + obm_pkg::StampW'(1) - best_q.stamp;
  always_comb begin
    cand_ok = rd_open_q && (rd_q.side != in_q.side) && (rd_q.prod == in_q.prod);
    if (in_q.side == obm_pkg::SideBuy) begin
      cand_ok = cand_ok && (rd_q.price <= in_q.price);
    end else begin
      cand_ok = cand_ok && (rd_q.price >= in_q.price);
    end
    if (!best_found_q) begin
      cand_beats = 1'b1;
    end else if (rd_q.price != best_q.price) begin
      cand_beats = (in_q.side == obm_pkg::SideBuy) ? (rd_q.price < best_q.price)
                                                   : (rd_q.price > best_q.price);
    end else begin
      cand_beats = age_cand > age_best;
    end
  end

  // trade size
  assign trade_ok = best_found_q && (in_q.qty != '0) && (best_q.qty != '0);
  assign tq       = (in_q.qty < best_q.qty) ? in_q.qty : best_q.qty;
  assign new_rem  = trade_ok ? (in_q.qty - tq) : in_q.qty;
  assign best_rem = best_q.qty - tq_q;

  // write port select
  always_comb begin
    we    = cmd_i.wr_new || cmd_i.wr_best;
    waddr = slot_q;
    wdata = in_q;
    if (cmd_i.wr_best) begin
      waddr = best_idx_q;
      wdata = best_q;
      wdata.qty = best_rem;
    end else begin
      wdata.qty   = new_rem;
      wdata.stamp = ctr_q;
    end
  end

  // control registers: scan state, open bits, counter, fee settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= '0;
      pct_q        <= obm_pkg::FeePctReset;
      ctr_q        <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      slot_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
      rd_vld_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.capture) begin
        cnt_q        <= '0;
        found_q      <= 1'b0;
        slot_found_q <= 1'b0;
        best_found_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (act_q == obm_pkg::ActCancel) begin
          if (rd_open_q && rd_q.trader == in_q.trader && rd_q.oid == in_q.oid) begin
            open_q[rd_idx_q] <= 1'b0;
            found_q <= 1'b1;
          end
        end else begin
          if (!rd_open_q && !slot_found_q) begin
            slot_found_q <= 1'b1;
          end
          if (cand_ok && cand_beats) begin
            best_found_q <= 1'b1;
          end
        end
      end
      if (cmd_i.wr_new) begin
        open_q[slot_q] <= (new_rem != '0) || !trade_ok;
        ctr_q <= ctr_q + 1'b1;
      end
      if (cmd_i.wr_best && best_rem == '0) begin
        open_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.fin) begin
        acc_q <= acc_sum[obm_pkg::TotalW] ? obm_pkg::TotalMax
                                          : acc_sum[obm_pkg::TotalW-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q        <= in_action_i;
      in_q.side    <= in_data_i[0];
      in_q.prod    <= in_data_i[8:1];
      in_q.price   <= in_data_i[32:9];
      in_q.qty     <= in_data_i[52:33];
      in_q.trader  <= in_data_i[60:53];
      in_q.oid     <= in_data_i[76:61];
      in_q.stamp   <= '0;
    end
    if (rd_vld_q && !cmd_i.capture && act_q == obm_pkg::ActPlace) begin
      if (!rd_open_q && !slot_found_q) begin
        slot_q <= rd_idx_q;
      end
      if (cand_ok && cand_beats) begin
        best_q     <= rd_q;
        best_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.wr_new) begin
      tq_q      <= tq;
      prod1_q   <= obm_pkg::Mul1W'(tq) * obm_pkg::Mul1W'(best_q.price);
      in_fill_q <= (new_rem == '0);
    end
    if (cmd_i.wr_best) begin
      prod2_q     <= obm_pkg::ProdFeeW'(prod1_q) * obm_pkg::ProdFeeW'(pct_q)
                   + obm_pkg::ProdFeeW'(50);
      rest_fill_q <= (best_rem == '0);
    end
    if (cmd_i.fin) begin
      fee_q <= (quot > obm_pkg::ProdFeeW'(obm_pkg::FeeMax)) ? obm_pkg::FeeMax
                                                           : quot[obm_pkg::FeeW-1:0];
    end
    if (cmd_i.out_load) begin
      out_status_o <= cmd_i.status;
      if (cmd_i.status == obm_pkg::StTraded) begin
        out_data_o <= {3'b000, acc_q, rest_fill_q, in_fill_q, best_q.oid,
                       best_q.trader, fee_q, best_q.price, tq_q};
      end else begin
        out_data_o <= {3'b000, acc_q, 110'd0};
      end
    end
  end

  assign acc_sum = {1'b0, acc_q} + (obm_pkg::TotalW + 1)'(quot);

  obm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod2_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // status toward the controller
  assign sts_o.is_cancel  = (act_q == obm_pkg::ActCancel);
  assign sts_o.scan_done  = (cnt_q == CW'(ENTRIES)) && !rd_vld_q;
  assign sts_o.found      = found_q;
  assign sts_o.slot_found = slot_found_q;
  assign sts_o.trade_ok   = trade_ok;
  assign sts_o.div_done   = div_done;

endmodule
